>>> hw/rtl/rwl_pkg.sv
// Shared types and constants of the reader/writer lock arbiter.
package rwl_pkg;

  // Sizing
  localparam int unsigned WRITER_QUEUE_DEPTH = 16;
  localparam int unsigned READER_QUEUE_DEPTH = 16;
  localparam int unsigned MAX_READERS        = 255;
  localparam int unsigned ID_BITS            = 6;
  localparam int unsigned KIND_W             = 3;
  localparam int unsigned EVENT_W            = 3;
  localparam int unsigned READERS_HELD_W     = 8;
  localparam int unsigned CMDQ_DEPTH         = 2;

  // Derived widths
  localparam int unsigned WQ_AW  = $clog2(WRITER_QUEUE_DEPTH);
  localparam int unsigned WQ_CW  = $clog2(WRITER_QUEUE_DEPTH + 1);
  localparam int unsigned RQ_AW  = $clog2(READER_QUEUE_DEPTH);
  localparam int unsigned RQ_CW  = $clog2(READER_QUEUE_DEPTH + 1);
  localparam int unsigned RC_W   = $clog2(MAX_READERS + 1);
  localparam int unsigned CMDQ_AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CW = $clog2(CMDQ_DEPTH + 1);

  // Request kinds as they arrive on the input channel
  typedef enum logic [KIND_W-1:0] {
    KIND_RD_ACQ = 3'd0,
    KIND_RD_TRY = 3'd1,
    KIND_RD_REL = 3'd2,
    KIND_WR_ACQ = 3'd3,
    KIND_WR_TRY = 3'd4,
    KIND_WR_REL = 3'd5
  } kind_e;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_RD_ACQ,
    OP_RD_TRY,
    OP_RD_REL,
    OP_WR_ACQ,
    OP_WR_TRY,
    OP_WR_REL,
    OP_BAD
  } op_e;

  // Result codes
  typedef enum logic [EVENT_W-1:0] {
    EV_GRANT    = 3'd0,
    EV_REFUSED  = 3'd1,
    EV_QUEUED   = 3'd2,
    EV_HANDOFF  = 3'd3,
    EV_RELEASED = 3'd4,
    EV_ERROR    = 3'd5
  } event_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_CMD,
    ST_HANDW,
    ST_WAKE
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [ID_BITS-1:0] id;
    logic              wr;
  } cmd_t;

  typedef struct packed {
    logic writer_held;
    logic readers_zero;
    logic waking;
  } stat_t;

endpackage

>>> hw/rtl/rwl_front.sv
// Front end: classifies incoming requests and buffers them in a short queue.
module rwl_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rwl_pkg::KIND_W-1:0]         kind_i,
  input  logic [rwl_pkg::ID_BITS-1:0]        requester_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output rwl_pkg::cmd_t                      cmd_o
);

  rwl_pkg::cmd_t                     dec_cmd;
  rwl_pkg::cmd_t                     ent_q [rwl_pkg::CMDQ_DEPTH];
  logic [rwl_pkg::CMDQ_AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rwl_pkg::CMDQ_AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rwl_pkg::CMDQ_CW-1:0]       cnt_q, cnt_d;
  logic                              push, pop;

  // Decode kind into an operation; unknown kinds become errors on the read side
  always_comb begin
    dec_cmd.id = requester_i;
    dec_cmd.wr = 1'b0;
    unique case (kind_i)
      rwl_pkg::KIND_RD_ACQ: dec_cmd.op = rwl_pkg::OP_RD_ACQ;
      rwl_pkg::KIND_RD_TRY: dec_cmd.op = rwl_pkg::OP_RD_TRY;
      rwl_pkg::KIND_RD_REL: dec_cmd.op = rwl_pkg::OP_RD_REL;
      rwl_pkg::KIND_WR_ACQ: begin
        dec_cmd.op = rwl_pkg::OP_WR_ACQ;
        dec_cmd.wr = 1'b1;
      end
      rwl_pkg::KIND_WR_TRY: begin
        dec_cmd.op = rwl_pkg::OP_WR_TRY;
        dec_cmd.wr = 1'b1;
      end
      rwl_pkg::KIND_WR_REL: begin
        dec_cmd.op = rwl_pkg::OP_WR_REL;
        dec_cmd.wr = 1'b1;
      end
      default: dec_cmd.op = rwl_pkg::OP_BAD;
    endcase
  end

  // Queue handshake
  assign in_ready_o  = (cnt_q != rwl_pkg::CMDQ_CW'(rwl_pkg::CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = ent_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == rwl_pkg::CMDQ_AW'(rwl_pkg::CMDQ_DEPTH - 1)) ? '0
                 : wr_ptr_q + rwl_pkg::CMDQ_AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == rwl_pkg::CMDQ_AW'(rwl_pkg::CMDQ_DEPTH - 1)) ? '0
                 : rd_ptr_q + rwl_pkg::CMDQ_AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + rwl_pkg::CMDQ_CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - rwl_pkg::CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

>>> hw/rtl/rwl_back.sv
// Back end: lock state, waiter queues and result sequencing.
module rwl_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  rwl_pkg::cmd_t                       cmd_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rwl_pkg::EVENT_W-1:0]         event_res_o,
  output logic [rwl_pkg::ID_BITS-1:0]         who_o,
  output logic                                as_writer_o,
  output logic [rwl_pkg::READERS_HELD_W-1:0]  readers_held_o,
  output logic                                last_o,
  output rwl_pkg::stat_t                      stat_o
);

  localparam int unsigned WQ_SW = rwl_pkg::WQ_CW + 1;
  localparam int unsigned RQ_SW = rwl_pkg::RQ_CW + 1;

  rwl_pkg::st_e                      state_q, state_d;
  logic [rwl_pkg::RC_W-1:0]          rc_q, rc_d, rc_inc, rc_dec;
  logic                              wh_q, wh_d;
  logic [rwl_pkg::ID_BITS-1:0]       wq_ids_q [rwl_pkg::WRITER_QUEUE_DEPTH];
  logic [rwl_pkg::ID_BITS-1:0]       rq_ids_q [rwl_pkg::READER_QUEUE_DEPTH];
  logic [rwl_pkg::WQ_AW-1:0]         wq_head_q, wq_head_d, wq_head_nxt, wq_tail;
  logic [rwl_pkg::RQ_AW-1:0]         rq_head_q, rq_head_d, rq_head_nxt, rq_tail;
  logic [rwl_pkg::WQ_CW-1:0]         wq_cnt_q, wq_cnt_d;
  logic [rwl_pkg::RQ_CW-1:0]         rq_cnt_q, rq_cnt_d;
  logic [WQ_SW-1:0]                  wq_sum;
  logic [RQ_SW-1:0]                  rq_sum;
  logic                              wake_all_q, wake_all_d;

  logic                              out_valid_q, out_valid_d;
  rwl_pkg::event_e                   out_ev_q, out_ev_d;
  logic [rwl_pkg::ID_BITS-1:0]       out_who_q, out_who_d;
  logic                              out_wr_q, out_wr_d;
  logic [rwl_pkg::RC_W-1:0]          out_rc_q, out_rc_d;
  logic                              out_last_q, out_last_d;

  logic slot_free, cmd_fire, go_w, go_r, wake_more, wq_push, rq_push;
  logic wr_busy, rd_blocked, rc_full, wq_full, rq_full;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == rwl_pkg::ST_CMD) && slot_free;
  assign cmd_fire    = cmd_ready_o && cmd_valid_i;

  assign rc_inc = rc_q + rwl_pkg::RC_W'(1);
  assign rc_dec = rc_q - rwl_pkg::RC_W'(1);

  // Lock conditions
  assign rd_blocked = wh_q || (wq_cnt_q != '0);
  assign wr_busy    = rd_blocked || (rc_q != '0);
  assign rc_full    = (rc_q >= rwl_pkg::RC_W'(rwl_pkg::MAX_READERS));
  assign wq_full    = (wq_cnt_q >= rwl_pkg::WQ_CW'(rwl_pkg::WRITER_QUEUE_DEPTH));
  assign rq_full    = (rq_cnt_q >= rwl_pkg::RQ_CW'(rwl_pkg::READER_QUEUE_DEPTH));

  // Ring indexes: tail is head plus count, wrapped once
  always_comb begin
    wq_sum = WQ_SW'(wq_head_q) + WQ_SW'(wq_cnt_q);
    if (wq_sum >= WQ_SW'(rwl_pkg::WRITER_QUEUE_DEPTH)) begin
      wq_sum = wq_sum - WQ_SW'(rwl_pkg::WRITER_QUEUE_DEPTH);
    end
    wq_tail = wq_sum[rwl_pkg::WQ_AW-1:0];
    rq_sum = RQ_SW'(rq_head_q) + RQ_SW'(rq_cnt_q);
    if (rq_sum >= RQ_SW'(rwl_pkg::READER_QUEUE_DEPTH)) begin
      rq_sum = rq_sum - RQ_SW'(rwl_pkg::READER_QUEUE_DEPTH);
    end
    rq_tail = rq_sum[rwl_pkg::RQ_AW-1:0];
    wq_head_nxt = (wq_head_q == rwl_pkg::WQ_AW'(rwl_pkg::WRITER_QUEUE_DEPTH - 1)) ? '0
                  : wq_head_q + rwl_pkg::WQ_AW'(1);
    rq_head_nxt = (rq_head_q == rwl_pkg::RQ_AW'(rwl_pkg::READER_QUEUE_DEPTH - 1)) ? '0
                  : rq_head_q + rwl_pkg::RQ_AW'(1);
  end

  // Datapath and result generation
  always_comb begin
    rc_d        = rc_q;
    wh_d        = wh_q;
    wq_head_d   = wq_head_q;
    wq_cnt_d    = wq_cnt_q;
    rq_head_d   = rq_head_q;
    rq_cnt_d    = rq_cnt_q;
    wake_all_d  = wake_all_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ev_d    = out_ev_q;
    out_who_d   = out_who_q;
    out_wr_d    = out_wr_q;
    out_rc_d    = out_rc_q;
    out_last_d  = out_last_q;
    wq_push     = 1'b0;
    rq_push     = 1'b0;
    go_w        = 1'b0;
    go_r        = 1'b0;
    wake_more   = 1'b0;

    unique case (state_q)
      rwl_pkg::ST_CMD: begin
        if (cmd_fire) begin
          out_valid_d = 1'b1;
          out_who_d   = cmd_i.id;
          out_wr_d    = cmd_i.wr;
          out_ev_d    = rwl_pkg::EV_ERROR;
          out_rc_d    = rc_q;
          out_last_d  = 1'b1;
          unique case (cmd_i.op)
            rwl_pkg::OP_RD_ACQ: begin
              if (rd_blocked) begin
                if (!rq_full) begin
                  rq_push  = 1'b1;
                  rq_cnt_d = rq_cnt_q + rwl_pkg::RQ_CW'(1);
                  out_ev_d = rwl_pkg::EV_QUEUED;
                end
              end else if (!rc_full) begin
                rc_d     = rc_inc;
                out_rc_d = rc_inc;
                out_ev_d = rwl_pkg::EV_GRANT;
              end
            end
            rwl_pkg::OP_RD_TRY: begin
              if (rd_blocked) begin
                out_ev_d = rwl_pkg::EV_REFUSED;
              end else if (!rc_full) begin
                rc_d     = rc_inc;
                out_rc_d = rc_inc;
                out_ev_d = rwl_pkg::EV_GRANT;
              end
            end
            rwl_pkg::OP_RD_REL: begin
              if (rc_q != '0 && !wh_q) begin
                rc_d       = rc_dec;
                out_rc_d   = rc_dec;
                out_ev_d   = rwl_pkg::EV_RELEASED;
                go_w       = (wq_cnt_q != '0) && (rc_dec == '0);
                go_r       = (wq_cnt_q == '0) && (rq_cnt_q != '0) &&
                             (rc_dec < rwl_pkg::RC_W'(rwl_pkg::MAX_READERS));
                wake_all_d = 1'b0;
                out_last_d = !(go_w || go_r);
              end
            end
            rwl_pkg::OP_WR_ACQ: begin
              if (wr_busy) begin
                if (!wq_full) begin
                  wq_push  = 1'b1;
                  wq_cnt_d = wq_cnt_q + rwl_pkg::WQ_CW'(1);
                  out_ev_d = rwl_pkg::EV_QUEUED;
                end
              end else begin
                wh_d     = 1'b1;
                out_ev_d = rwl_pkg::EV_GRANT;
              end
            end
            rwl_pkg::OP_WR_TRY: begin
              if (wr_busy) begin
                out_ev_d = rwl_pkg::EV_REFUSED;
              end else begin
                wh_d     = 1'b1;
                out_ev_d = rwl_pkg::EV_GRANT;
              end
            end
            rwl_pkg::OP_WR_REL: begin
              if (wh_q) begin
                wh_d       = 1'b0;
                out_ev_d   = rwl_pkg::EV_RELEASED;
                go_w       = (wq_cnt_q != '0);
                go_r       = (wq_cnt_q == '0) && (rq_cnt_q != '0) && !rc_full;
                wake_all_d = 1'b1;
                out_last_d = !(go_w || go_r);
              end
            end
            default: ;
          endcase
        end
      end

      // Hand the lock to the head waiting writer
      rwl_pkg::ST_HANDW: begin
        if (slot_free) begin
          wh_d        = 1'b1;
          wq_head_d   = wq_head_nxt;
          wq_cnt_d    = wq_cnt_q - rwl_pkg::WQ_CW'(1);
          out_valid_d = 1'b1;
          out_ev_d    = rwl_pkg::EV_HANDOFF;
          out_who_d   = wq_ids_q[wq_head_q];
          out_wr_d    = 1'b1;
          out_rc_d    = rc_q;
          out_last_d  = 1'b1;
        end
      end

      // Hand the lock to waiting readers, one per cycle while the output slot is free
      rwl_pkg::ST_WAKE: begin
        if (slot_free) begin
          rc_d        = rc_inc;
          rq_head_d   = rq_head_nxt;
          rq_cnt_d    = rq_cnt_q - rwl_pkg::RQ_CW'(1);
          wake_more   = wake_all_q && (rq_cnt_q != rwl_pkg::RQ_CW'(1)) &&
                        (rc_inc < rwl_pkg::RC_W'(rwl_pkg::MAX_READERS));
          out_valid_d = 1'b1;
          out_ev_d    = rwl_pkg::EV_HANDOFF;
          out_who_d   = rq_ids_q[rq_head_q];
          out_wr_d    = 1'b0;
          out_rc_d    = rc_inc;
          out_last_d  = !wake_more;
        end
      end

      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rwl_pkg::ST_CMD: begin
        if (cmd_fire && go_w) begin
          state_d = rwl_pkg::ST_HANDW;
        end else if (cmd_fire && go_r) begin
          state_d = rwl_pkg::ST_WAKE;
        end
      end
      rwl_pkg::ST_HANDW: begin
        if (slot_free) begin
          state_d = rwl_pkg::ST_CMD;
        end
      end
      rwl_pkg::ST_WAKE: begin
        if (slot_free && !wake_more) begin
          state_d = rwl_pkg::ST_CMD;
        end
      end
      default: state_d = rwl_pkg::ST_CMD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwl_pkg::ST_CMD;
      rc_q        <= '0;
      wh_q        <= 1'b0;
      wq_head_q   <= '0;
      wq_cnt_q    <= '0;
      rq_head_q   <= '0;
      rq_cnt_q    <= '0;
      wake_all_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rc_q        <= rc_d;
      wh_q        <= wh_d;
      wq_head_q   <= wq_head_d;
      wq_cnt_q    <= wq_cnt_d;
      rq_head_q   <= rq_head_d;
      rq_cnt_q    <= rq_cnt_d;
      wake_all_q  <= wake_all_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload and waiter id storage
  always_ff @(posedge clk_i) begin
    out_ev_q   <= out_ev_d;
    out_who_q  <= out_who_d;
    out_wr_q   <= out_wr_d;
    out_rc_q   <= out_rc_d;
    out_last_q <= out_last_d;
    if (wq_push) begin
      wq_ids_q[wq_tail] <= cmd_i.id;
    end
    if (rq_push) begin
      rq_ids_q[rq_tail] <= cmd_i.id;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = out_ev_q;
  assign who_o          = out_who_q;
  assign as_writer_o    = out_wr_q;
  assign readers_held_o = rwl_pkg::READERS_HELD_W'(out_rc_q);
  assign last_o         = out_last_q;

  assign stat_o.writer_held  = wh_q;
  assign stat_o.readers_zero = (rc_q == '0);
  assign stat_o.waking       = (state_q == rwl_pkg::ST_WAKE);

endmodule

>>> hw/rtl/reader_writer_lock_arbiter_top.sv
// Writer-preferring reader/writer lock arbiter.
//
// Input channel (in_valid_i/in_ready_o) carries one lock request per transfer:
// kind_i selects read/write acquire, try or release, requester_i tags the agent.
// Output channel (out_valid_o/out_ready_i) returns one or more results per
// request; last_o marks the final result of a request.
// A two-entry request queue decouples the front end from the lock sequencer,
// so requests are taken while a result waits for the receiver.
// A request is registered in the request queue and its first result in the
// output register before it is presented. Requests with a single result are
// taken one per cycle while the receiver accepts results; a release that hands
// the lock on emits its release result and then one handoff result per woken
// waiter, and the sequencer takes no new request until the last one is sent.
// Reset leaves the lock free: no readers, no writer, both waiter queues empty.
// When the receiver stalls, the output register holds its result, the
// sequencer stops, the request queue fills and in_ready_o drops.
module reader_writer_lock_arbiter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rwl_pkg::KIND_W-1:0]          kind_i,
  input  logic [rwl_pkg::ID_BITS-1:0]         requester_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rwl_pkg::EVENT_W-1:0]         event_res_o,
  output logic [rwl_pkg::ID_BITS-1:0]         who_o,
  output logic                                as_writer_o,
  output logic [rwl_pkg::READERS_HELD_W-1:0]  readers_held_o,
  output logic                                last_o
);

  logic           cmd_valid, cmd_ready;
  rwl_pkg::cmd_t  cmd;
  rwl_pkg::stat_t stat;

  rwl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .requester_i (requester_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rwl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .who_o          (who_o),
    .as_writer_o    (as_writer_o),
    .readers_held_o (readers_held_o),
    .last_o         (last_o),
    .stat_o         (stat)
  );

  // A held write lock excludes active readers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.writer_held |-> stat.readers_zero)
    else $error("writer holds lock with active readers");

  // Waking readers only happens with the write lock free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.waking |-> !stat.writer_held)
    else $error("reader wake while writer holds lock");

  // Any write grant reports zero active readers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && as_writer_o &&
     (event_res_o == rwl_pkg::EV_GRANT || event_res_o == rwl_pkg::EV_HANDOFF))
    |-> (readers_held_o == '0))
    else $error("write grant with readers held");

endmodule
